>>> rtl/core/tgad_pkg.sv
// Shared types and constants for the TGA true-color stream decoder.
// Used by the decoder top level and its port checker; depends on nothing else.

package tgad_pkg;

    // Default largest accepted image side in pixels.
    localparam int MAX_DIM_DEFAULT = 8192;

    // Depth of the result queue and its pointer and count widths.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Width of the size fields in an info result.
    localparam int SIZE_W = 14;

    // Header byte positions that carry meaning.
    localparam logic [4:0] HDR_ID_LEN     = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_DEPTH      = 5'd16;
    localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

    // Accepted header codes.
    localparam logic [7:0] TYPE_RAW  = 8'd2;
    localparam logic [7:0] TYPE_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24  = 8'd24;
    localparam logic [7:0] DEPTH_32  = 8'd32;
    localparam int         DESC_TOP_BIT = 5;
    localparam int         PKT_RUN_BIT  = 7;
    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_INFO  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PKTHDR = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_DONE   = 3'd4,
        PH_HALT   = 3'd5
    } phase_t;

    // Parse state, apart from the pixel count and the pixel byte buffer.
    typedef struct packed {
        phase_t      phase;
        logic [4:0]  hdr_idx;
        logic        hdr_bad;
        logic [7:0]  id_left;
        logic        is_rle;
        logic        four_byte;
        logic [15:0] img_w;
        logic [15:0] img_h;
        logic        top_first;
        logic [7:0]  pkt_left;
        logic        pkt_run;
        logic [1:0]  pix_idx;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:     PH_HEADER,
        hdr_idx:   5'd0,
        hdr_bad:   1'b0,
        id_left:   8'd0,
        is_rle:    1'b0,
        four_byte: 1'b0,
        img_w:     16'd0,
        img_h:     16'd0,
        top_first: 1'b0,
        pkt_left:  8'd0,
        pkt_run:   1'b0,
        pix_idx:   2'd0
    };

    // One result item.
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [7:0]         repeat_res;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic               rows_from_top;
        logic               alpha_in_src;
        logic               last;
    } result_t;

    localparam result_t RES_ERROR = '{
        kind:          KIND_ERROR,
        red:           8'd0,
        green:         8'd0,
        blue:          8'd0,
        alpha:         8'd0,
        repeat_res:    8'd0,
        width:         '0,
        height:        '0,
        rows_from_top: 1'b0,
        alpha_in_src:  1'b0,
        last:          1'b0
    };

endpackage

>>> rtl/core/tga_truecolor_stream_decoder.sv
// Top level of the TGA true-color stream decoder: input register, byte parser
// and result queue. Depends on tgad_pkg.

// The decoder takes one TGA file byte per transaction and accepts a new byte
// in every cycle while the result side keeps up. A byte is held in the
// input register, where the header, packet and pixel parsing for it is done in
// a single pass, and its results land in a four-entry result queue that the
// output side drains one transaction per cycle while out_stall is low. A byte
// gives at most two results (a pixel, info or header error result followed by
// an early-end error), so the input side stalls only while the queue holds more
// than two results. The pixel count of an image is formed with one 16 by 16 bit
// multiply when the header's last byte is parsed.

module tga_truecolor_stream_decoder
    import tgad_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
    input  logic                clk,
    input  logic                rst_n,
    // Byte input channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                final_byte,
    // Result output channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [7:0]          alpha,
    output logic [7:0]          repeat_res,
    output logic [SIZE_W-1:0]   width,
    output logic [SIZE_W-1:0]   height,
    output logic                rows_from_top,
    output logic                alpha_in_src,
    output logic                last
);

    // Pixel count width: enough for MAX_DIM squared and for a packet length.
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int PIX_W = (2 * DIM_W > 8) ? 2 * DIM_W : 8;
    localparam logic [15:0] MAX_DIM_V = 16'(MAX_DIM);

    // Input register.
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          data_reg;
    logic                first_reg;
    logic                final_reg;

    // Parse state.
    ctl_t                ctl_reg;
    ctl_t                ctl_next;
    logic [PIX_W-1:0]    pixels_left_reg;
    logic [PIX_W-1:0]    pixels_left_next;
    logic [7:0]          pix_buf_reg [3];

    // Result queue.
    result_t             rq_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] wr_ptr_next;
    logic [RQ_PTR_W-1:0] wr_ptr_p1;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_next;
    logic [RQ_CNT_W-1:0] count_reg;
    logic [RQ_CNT_W-1:0] count_next;

    // Parser outputs.
    ctl_t                cur;
    logic [PIX_W-1:0]    pl_cur;
    logic [PIX_W-1:0]    pl_after;
    logic [31:0]         area;
    logic                hdr_fail;
    logic [7:0]          rep;
    logic                buf_we;
    logic                res_v;
    logic                err_v;
    result_t             res;
    result_t             push_a;
    logic [1:0]          push_n;
    logic                advance;
    logic                go;
    logic                in_accept;
    logic                pop;
    result_t             head;

    // Handshake: the held byte moves on when the queue has room for two results.
    assign advance   = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign go        = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg  <= data_byte;
            first_reg <= first_byte;
            final_reg <= final_byte;
        end
    end

    // Byte parser: one header, ID, packet or pixel byte per transaction.
    always_comb
    begin
        cur      = first_reg ? CTL_RESET : ctl_reg;
        pl_cur   = first_reg ? '0 : pixels_left_reg;
        ctl_next = cur;
        pixels_left_next = pl_cur;
        pl_after = pl_cur;
        area     = 32'(cur.img_w) * 32'(cur.img_h);
        hdr_fail = cur.hdr_bad || (cur.img_w == 16'd0) || (cur.img_h == 16'd0) ||
                   (cur.img_w > MAX_DIM_V) || (cur.img_h > MAX_DIM_V);
        rep      = 8'd1;
        buf_we   = 1'b0;
        res_v    = 1'b0;
        err_v    = 1'b0;
        res      = RES_ERROR;

        case (cur.phase)
            PH_HEADER:
            begin
                case (cur.hdr_idx)
                    HDR_ID_LEN:     ctl_next.id_left = data_reg;
                    HDR_CMAP_TYPE:  ctl_next.hdr_bad = cur.hdr_bad || (data_reg != 8'd0);
                    HDR_IMAGE_TYPE:
                    begin
                        if (data_reg == TYPE_RLE)
                        begin
                            ctl_next.is_rle = 1'b1;
                        end
                        else if (data_reg == TYPE_RAW)
                        begin
                            ctl_next.is_rle = 1'b0;
                        end
                        else
                        begin
                            ctl_next.hdr_bad = 1'b1;
                        end
                    end
                    HDR_WIDTH_LO:   ctl_next.img_w = {cur.img_w[15:8], data_reg};
                    HDR_WIDTH_HI:   ctl_next.img_w = {data_reg, cur.img_w[7:0]};
                    HDR_HEIGHT_LO:  ctl_next.img_h = {cur.img_h[15:8], data_reg};
                    HDR_HEIGHT_HI:  ctl_next.img_h = {data_reg, cur.img_h[7:0]};
                    HDR_DEPTH:
                    begin
                        if (data_reg == DEPTH_32)
                        begin
                            ctl_next.four_byte = 1'b1;
                        end
                        else if (data_reg == DEPTH_24)
                        begin
                            ctl_next.four_byte = 1'b0;
                        end
                        else
                        begin
                            ctl_next.hdr_bad = 1'b1;
                        end
                    end
                    default: ;
                endcase

                if (cur.hdr_idx != HDR_DESCRIPTOR)
                begin
                    ctl_next.hdr_idx = cur.hdr_idx + 5'd1;
                end
                else
                begin
                    ctl_next.top_first = data_reg[DESC_TOP_BIT];
                    res_v = 1'b1;
                    if (hdr_fail)
                    begin
                        ctl_next.phase = PH_HALT;
                    end
                    else
                    begin
                        res.kind          = KIND_INFO;
                        res.width         = cur.img_w[SIZE_W-1:0];
                        res.height        = cur.img_h[SIZE_W-1:0];
                        res.rows_from_top = data_reg[DESC_TOP_BIT];
                        res.alpha_in_src  = cur.four_byte;
                        pixels_left_next  = PIX_W'(area);
                        ctl_next.pkt_left = 8'd0;
                        ctl_next.pkt_run  = 1'b0;
                        ctl_next.pix_idx  = 2'd0;
                        if (cur.id_left != 8'd0)
                        begin
                            ctl_next.phase = PH_IDSKIP;
                        end
                        else
                        begin
                            ctl_next.phase = cur.is_rle ? PH_PKTHDR : PH_PIXEL;
                        end
                    end
                end
            end

            PH_IDSKIP:
            begin
                if (cur.id_left != 8'd0)
                begin
                    ctl_next.id_left = cur.id_left - 8'd1;
                end
                if (ctl_next.id_left == 8'd0)
                begin
                    ctl_next.phase = cur.is_rle ? PH_PKTHDR : PH_PIXEL;
                end
            end

            PH_PKTHDR:
            begin
                ctl_next.pkt_run  = data_reg[PKT_RUN_BIT];
                ctl_next.pkt_left = {1'b0, data_reg[PKT_RUN_BIT-1:0]} + 8'd1;
                ctl_next.pix_idx  = 2'd0;
                ctl_next.phase    = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                if (cur.pix_idx < (cur.four_byte ? 2'd3 : 2'd2))
                begin
                    // Collect a color byte until the last byte of the pixel.
                    buf_we = 1'b1;
                    ctl_next.pix_idx = cur.pix_idx + 2'd1;
                end
                else
                begin
                    ctl_next.pix_idx = 2'd0;
                    if (cur.is_rle && cur.pkt_run)
                    begin
                        rep = (PIX_W'(cur.pkt_left) > pl_cur) ? 8'(pl_cur) : cur.pkt_left;
                        ctl_next.pkt_left = 8'd0;
                    end
                    else if (cur.is_rle && (cur.pkt_left != 8'd0))
                    begin
                        ctl_next.pkt_left = cur.pkt_left - 8'd1;
                    end
                    pl_after = pl_cur - PIX_W'(rep);
                    pixels_left_next = pl_after;

                    res_v             = 1'b1;
                    res.kind          = KIND_PIXEL;
                    res.blue          = pix_buf_reg[0];
                    res.green         = pix_buf_reg[1];
                    res.red           = cur.four_byte ? pix_buf_reg[2] : data_reg;
                    res.alpha         = cur.four_byte ? data_reg : OPAQUE_ALPHA;
                    res.repeat_res    = rep;
                    res.rows_from_top = cur.top_first;
                    res.alpha_in_src  = cur.four_byte;
                    res.last          = (pl_after == '0);

                    if (pl_after == '0)
                    begin
                        ctl_next.phase = PH_DONE;
                    end
                    else if (cur.is_rle && (cur.pkt_run || (ctl_next.pkt_left == 8'd0)))
                    begin
                        ctl_next.phase = PH_PKTHDR;
                    end
                    else
                    begin
                        ctl_next.phase = PH_PIXEL;
                    end
                end
            end

            default: ;
        endcase

        // A file that ends before its image is complete gives an error.
        if (final_reg && (ctl_next.phase != PH_DONE) && (ctl_next.phase != PH_HALT))
        begin
            err_v = 1'b1;
            ctl_next.phase = PH_HALT;
        end
    end

    // Results of the byte in order: the parsed result first, then the error.
    assign push_a = res_v ? res : RES_ERROR;
    assign push_n = go ? (2'(res_v) + 2'(err_v)) : 2'd0;

    // Control and parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            ctl_reg         <= CTL_RESET;
            pixels_left_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (go)
            begin
                ctl_reg         <= ctl_next;
                pixels_left_reg <= pixels_left_next;
            end
        end
    end

    // Pixel byte buffer.
    always_ff @(posedge clk)
    begin
        if (go && buf_we)
        begin
            pix_buf_reg[cur.pix_idx] <= data_reg;
        end
    end

    // Result queue pointers and fill count.
    assign wr_ptr_p1   = wr_ptr_reg + RQ_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_n);
    assign rd_ptr_next = pop ? (rd_ptr_reg + RQ_PTR_W'(1)) : rd_ptr_reg;
    assign count_next  = count_reg + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            rq_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            rq_reg[wr_ptr_p1] <= RES_ERROR;
        end
    end

    // Output fields come from the queue head.
    assign head          = rq_reg[rd_ptr_reg];
    assign kind          = head.kind;
    assign red           = head.red;
    assign green         = head.green;
    assign blue          = head.blue;
    assign alpha         = head.alpha;
    assign repeat_res    = head.repeat_res;
    assign width         = head.width;
    assign height        = head.height;
    assign rows_from_top = head.rows_from_top;
    assign alpha_in_src  = head.alpha_in_src;
    assign last          = head.last;

endmodule

>>> rtl/core/tgad_checker.sv
// Port checker for the TGA true-color stream decoder, bound to the top level.
// Depends on tgad_pkg and on the port names of tga_truecolor_stream_decoder.

module tgad_checker
    import tgad_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         kind,
    input logic [7:0]         red,
    input logic [7:0]         green,
    input logic [7:0]         blue,
    input logic [7:0]         alpha,
    input logic [7:0]         repeat_res,
    input logic [SIZE_W-1:0]  width,
    input logic [SIZE_W-1:0]  height,
    input logic               rows_from_top,
    input logic               alpha_in_src,
    input logic               last
);

    // A stalled result transaction keeps its kind, red, repeat count and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(red) &&
            $stable(repeat_res) && $stable(last))
        else $error("stalled result changed");

    // An error result carries nothing but its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |-> (red == 8'd0) && (green == 8'd0) &&
            (blue == 8'd0) && (alpha == 8'd0) && (repeat_res == 8'd0) &&
            (width == '0) && (height == '0) && !rows_from_top && !alpha_in_src && !last)
        else $error("error result with nonzero fields");

    // A pixel result covers one to one hundred twenty-eight pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PIXEL) |-> (repeat_res != 8'd0) &&
            (repeat_res <= 8'd128))
        else $error("pixel repeat count out of range");

    // Pixels from a 24-bit image are opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PIXEL) && !alpha_in_src |-> (alpha == OPAQUE_ALPHA))
        else $error("24-bit pixel not opaque");

endmodule

bind tga_truecolor_stream_decoder tgad_checker u_tgad_checker (.*);
